// ----- design/fct_pkg.sv -----
// Shared types and codes for the frustum cull tester.
// Holds the item structs, the controller/datapath command and status structs and op codes.
// No dependencies.
package fct_pkg;

  localparam int OP_W  = 4;
  localparam int CNT_W = 7;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_BOX    = 2'd1;
  localparam logic [1:0] REQ_SPHERE = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  localparam logic [OP_W-1:0] OP_IDLE     = 4'd0;
  localparam logic [OP_W-1:0] OP_CAPTURE  = 4'd1;
  localparam logic [OP_W-1:0] OP_LOAD_ROW = 4'd2;
  localparam logic [OP_W-1:0] OP_PSUM     = 4'd3;
  localparam logic [OP_W-1:0] OP_SHIFT    = 4'd4;
  localparam logic [OP_W-1:0] OP_SQ       = 4'd5;
  localparam logic [OP_W-1:0] OP_SQRT     = 4'd6;
  localparam logic [OP_W-1:0] OP_LEN      = 4'd7;
  localparam logic [OP_W-1:0] OP_DIV_INIT = 4'd8;
  localparam logic [OP_W-1:0] OP_DIV_STEP = 4'd9;
  localparam logic [OP_W-1:0] OP_DIV_FIN  = 4'd10;
  localparam logic [OP_W-1:0] OP_STORE    = 4'd11;
  localparam logic [OP_W-1:0] OP_TERM     = 4'd12;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [1:0]         row_index;
    logic signed [31:0] val_a;
    logic signed [31:0] val_b;
    logic signed [31:0] val_c;
    logic signed [31:0] val_d;
    logic [30:0]        half_x;
    logic [30:0]        half_y;
    logic [30:0]        half_z;
  } in_t;

  typedef struct packed {
    logic resp_kind;
    logic visible;
  } out_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [2:0]       k;
    logic [1:0]       j;
    logic [CNT_W-1:0] cnt;
    logic             box;
  } cmd_t;

  typedef struct packed {
    logic shift_more;
    logic len_big;
    logic acc_neg;
  } stat_t;

endpackage

// ----- design/fct_datapath.sv -----
// Datapath of the frustum cull tester: matrix and plane registers, plane rebuild
// arithmetic (sum, square root, restoring divide) and the test accumulator.
// Depends on fct_pkg.
module fct_datapath #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  fct_pkg::in_t  in_data,
  input  fct_pkg::cmd_t cmd,
  output fct_pkg::stat_t stat
);

  localparam int W     = WORD_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int MW    = W + F;
  localparam int PW    = W + 34;
  localparam int ACC_W = W + 40;
  localparam logic [63:0] LEN_MIN = 64'(((64'd1 << F) + 64'd5000) / 64'd10000);
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
  localparam logic [W+1:0] CAP2 = (W + 2)'(1) << W;
  localparam logic [W:0]   CAP1 = (W + 1)'(1) << W;

  function automatic logic signed [W-1:0] sat_w(input logic signed [63:0] v);
    if (v > SAT_HI) return SAT_HI[W-1:0];
    if (v < SAT_LO) return SAT_LO[W-1:0];
    return v[W-1:0];
  endfunction

  function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] p);
    logic [W-1:0] pu;
    pu = p;
    return p[W-1] ? (~pu + 1'b1) : pu;
  endfunction

  fct_pkg::in_t       cap_r;
  logic signed [W-1:0] matrix_r [4][4];
  logic signed [W-1:0] plane_r  [6][4];
  logic signed [W-1:0] p_r      [4];
  logic [W-1:0]        mag_r    [3];
  logic [4:0]          s_r;
  logic [63:0]         v_r, r_r, len_r, rem_r;
  logic [MW-1:0]       m_sh_r;
  logic [W:0]          q_r;
  logic                big_r;
  logic signed [ACC_W-1:0] acc_r;

  // plane sums
  logic signed [W-1:0] psum [4];
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (cmd.k[0])
        psum[j] = sat_w(64'(matrix_r[3][j]) - 64'(matrix_r[cmd.k[2:1]][j]));
      else
        psum[j] = sat_w(64'(matrix_r[3][j]) + 64'(matrix_r[cmd.k[2:1]][j]));
    end
  end

  logic shift_more;
  always_comb begin
    shift_more = 1'b0;
    for (int i = 0; i < 3; i++) shift_more = shift_more | (|(64'(mag_r[i]) >> 31));
  end

  // sum of squares
  logic [W-1:0]  sq_sel;
  logic [63:0]   sq_ext;
  logic [30:0]   sq_c;
  always_comb begin
    case (cmd.cnt[1:0])
      2'd0:    sq_sel = mag_r[0];
      2'd1:    sq_sel = mag_r[1];
      default: sq_sel = mag_r[2];
    endcase
    sq_ext = 64'(sq_sel);
    sq_c   = sq_ext[30:0];
  end

  // square root step
  logic [63:0] sq_b, sq_rb;
  logic        sq_ge;
  always_comb begin
    sq_b  = 64'd1 << (6'd62 - {cmd.cnt[4:0], 1'b0});
    sq_rb = r_r + sq_b;
    sq_ge = v_r >= sq_rb;
  end

  // restoring divide step
  logic [63:0]  rem_s, rem_n;
  logic         div_ge;
  logic [W+1:0] q_n;
  always_comb begin
    rem_s  = {rem_r[62:0], m_sh_r[MW-1]};
    div_ge = rem_s >= len_r;
    rem_n  = div_ge ? rem_s - len_r : rem_s;
    q_n    = {q_r, div_ge};
  end

  // divide finish: round, apply sign, saturate
  logic                rnd;
  logic [W:0]          q_f;
  logic signed [W+1:0] q_s;
  always_comb begin
    rnd = rem_r >= (len_r - rem_r);
    q_f = big_r ? CAP1 : q_r + (W + 1)'(rnd);
    q_s = p_r[cmd.j][W-1] ? -$signed({1'b0, q_f}) : $signed({1'b0, q_f});
  end

  // test term
  logic signed [W:0]       mul_a;
  logic signed [32:0]      mul_b;
  logic signed [PW-1:0]    prod;
  logic signed [ACC_W-1:0] term;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.cnt[2:0])
      3'd1: begin mul_a = (W + 1)'(plane_r[cmd.k][0]); mul_b = 33'(cap_r.val_a); end
      3'd2: begin mul_a = (W + 1)'(plane_r[cmd.k][1]); mul_b = 33'(cap_r.val_b); end
      3'd3: begin mul_a = (W + 1)'(plane_r[cmd.k][2]); mul_b = 33'(cap_r.val_c); end
      3'd4: begin
        mul_a = $signed({1'b0, mag_w(plane_r[cmd.k][0])});
        mul_b = $signed({2'b00, cap_r.half_x});
      end
      3'd5: begin
        mul_a = $signed({1'b0, mag_w(plane_r[cmd.k][1])});
        mul_b = $signed({2'b00, cap_r.half_y});
      end
      3'd6: begin
        mul_a = $signed({1'b0, mag_w(plane_r[cmd.k][2])});
        mul_b = $signed({2'b00, cap_r.half_z});
      end
      default: ;
    endcase
    prod = mul_a * mul_b;
    case (cmd.cnt[2:0]) inside
      3'd0:          term = ACC_W'(plane_r[cmd.k][3]) <<< F;
      3'd1, 3'd2, 3'd3: term = ACC_W'(prod);
      3'd4:          term = cmd.box ? ACC_W'(prod) : (ACC_W'(cap_r.val_d) <<< F);
      3'd5, 3'd6:    term = cmd.box ? ACC_W'(prod) : '0;
      default:       term = '0;
    endcase
  end

  // stored state, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 4; r++)
        for (int j = 0; j < 4; j++) matrix_r[r][j] <= '0;
      for (int k = 0; k < 6; k++)
        for (int j = 0; j < 4; j++) plane_r[k][j] <= '0;
    end else begin
      if (cmd.op == fct_pkg::OP_LOAD_ROW) begin
        matrix_r[cap_r.row_index][0] <= sat_w(64'(cap_r.val_a));
        matrix_r[cap_r.row_index][1] <= sat_w(64'(cap_r.val_b));
        matrix_r[cap_r.row_index][2] <= sat_w(64'(cap_r.val_c));
        matrix_r[cap_r.row_index][3] <= sat_w(64'(cap_r.val_d));
      end
      if (cmd.op == fct_pkg::OP_STORE) begin
        for (int j = 0; j < 4; j++) plane_r[cmd.k][j] <= p_r[j];
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      fct_pkg::OP_CAPTURE: cap_r <= in_data;
      fct_pkg::OP_PSUM: begin
        for (int j = 0; j < 4; j++) p_r[j] <= psum[j];
        for (int j = 0; j < 3; j++) mag_r[j] <= mag_w(psum[j]);
        s_r <= '0;
        v_r <= '0;
        r_r <= '0;
      end
      fct_pkg::OP_SHIFT: begin
        if (shift_more) begin
          for (int j = 0; j < 3; j++) mag_r[j] <= mag_r[j] >> 1;
          s_r <= s_r + 5'd1;
        end
      end
      fct_pkg::OP_SQ: v_r <= v_r + 64'(sq_c) * 64'(sq_c);
      fct_pkg::OP_SQRT: begin
        if (sq_ge) begin
          v_r <= v_r - sq_rb;
          r_r <= (r_r >> 1) + sq_b;
        end else begin
          r_r <= r_r >> 1;
        end
      end
      fct_pkg::OP_LEN: len_r <= r_r << s_r;
      fct_pkg::OP_DIV_INIT: begin
        m_sh_r <= {mag_w(p_r[cmd.j]), F'(0)};
        rem_r  <= '0;
        q_r    <= '0;
        big_r  <= 1'b0;
      end
      fct_pkg::OP_DIV_STEP: begin
        m_sh_r <= m_sh_r << 1;
        rem_r  <= rem_n;
        q_r    <= q_n[W:0];
        big_r  <= big_r | (q_n >= CAP2);
      end
      fct_pkg::OP_DIV_FIN: p_r[cmd.j] <= sat_w(64'(q_s));
      fct_pkg::OP_TERM: acc_r <= (cmd.cnt[2:0] == 3'd0) ? term : acc_r + term;
      default: ;
    endcase
  end

  assign stat.shift_more = shift_more;
  assign stat.len_big    = len_r > LEN_MIN;
  assign stat.acc_neg    = acc_r[ACC_W-1];

endmodule

// ----- design/fct_ctrl.sv -----
// Controller of the frustum cull tester: sequences loads, plane rebuilds and tests,
// and owns the handshake and the result register. Depends on fct_pkg.
module fct_ctrl #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_req,
  output logic           out_valid,
  input  logic           out_ready,
  output fct_pkg::out_t  out_data,
  output fct_pkg::cmd_t  cmd,
  input  fct_pkg::stat_t stat
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_PSUM  = 4'd2;
  localparam logic [3:0] S_SHIFT = 4'd3;
  localparam logic [3:0] S_SQ    = 4'd4;
  localparam logic [3:0] S_SQRT  = 4'd5;
  localparam logic [3:0] S_LEN   = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_DIVI  = 4'd8;
  localparam logic [3:0] S_DIVS  = 4'd9;
  localparam logic [3:0] S_DIVF  = 4'd10;
  localparam logic [3:0] S_STORE = 4'd11;
  localparam logic [3:0] S_TEST  = 4'd12;

  localparam logic [fct_pkg::CNT_W-1:0] DIV_LAST =
    fct_pkg::CNT_W'(WORD_WIDTH + FRAC_BITS - 1);

  logic [3:0]                state_r, state_nxt;
  logic [2:0]                k_r, k_nxt;
  logic [1:0]                j_r, j_nxt;
  logic [fct_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      box_r, box_nxt;
  logic                      out_valid_r, out_valid_nxt;
  fct_pkg::out_t             out_data_r, out_data_nxt;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    box_nxt       = box_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    cmd.op        = fct_pkg::OP_IDLE;
    cmd.k         = k_r;
    cmd.j         = j_r;
    cmd.cnt       = cnt_r;
    cmd.box       = box_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.op  = fct_pkg::OP_CAPTURE;
          k_nxt   = 3'd0;
          cnt_nxt = '0;
          box_nxt = (in_req == fct_pkg::REQ_BOX);
          case (in_req)
            fct_pkg::REQ_LOAD: state_nxt = S_LOAD;
            fct_pkg::REQ_NONE: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
            end
            default: state_nxt = S_TEST;
          endcase
        end
      end
      S_LOAD: begin
        cmd.op    = fct_pkg::OP_LOAD_ROW;
        state_nxt = S_PSUM;
      end
      S_PSUM: begin
        cmd.op    = fct_pkg::OP_PSUM;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.op = fct_pkg::OP_SHIFT;
        if (!stat.shift_more) begin
          cnt_nxt   = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op = fct_pkg::OP_SQ;
        if (cnt_r == fct_pkg::CNT_W'(2)) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SQRT: begin
        cmd.op = fct_pkg::OP_SQRT;
        if (cnt_r == fct_pkg::CNT_W'(31)) state_nxt = S_LEN;
        else cnt_nxt = cnt_r + 1'b1;
      end
      S_LEN: begin
        cmd.op    = fct_pkg::OP_LEN;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        j_nxt     = 2'd0;
        state_nxt = stat.len_big ? S_DIVI : S_STORE;
      end
      S_DIVI: begin
        cmd.op    = fct_pkg::OP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        cmd.op = fct_pkg::OP_DIV_STEP;
        if (cnt_r == DIV_LAST) state_nxt = S_DIVF;
        else cnt_nxt = cnt_r + 1'b1;
      end
      S_DIVF: begin
        cmd.op = fct_pkg::OP_DIV_FIN;
        if (j_r == 2'd3) begin
          state_nxt = S_STORE;
        end else begin
          j_nxt     = j_r + 2'd1;
          state_nxt = S_DIVI;
        end
      end
      S_STORE: begin
        cmd.op = fct_pkg::OP_STORE;
        if (k_r == 3'd5) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = S_PSUM;
        end
      end
      S_TEST: begin
        cmd.op = fct_pkg::OP_TERM;
        if (cnt_r[2:0] == 3'd7) begin
          cnt_nxt = '0;
          if (stat.acc_neg || k_r == 3'd5) begin
            state_nxt              = S_IDLE;
            out_valid_nxt          = 1'b1;
            out_data_nxt.resp_kind = 1'b1;
            out_data_nxt.visible   = !stat.acc_neg;
          end else begin
            k_nxt = k_r + 3'd1;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      j_r         <= '0;
      cnt_r       <= '0;
      box_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      cnt_r       <= cnt_nxt;
      box_r       <= box_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- design/frustum_cull_tester_core.sv -----
// Frustum cull tester: one item at a time. A test walks the planes in turn through one
// shared multiplier, with an early exit on the first plane the object is behind. A row
// load rebuilds six planes, each through the bit-serial square root and, when the
// length is large enough, the bit-serial restoring divider.
// Synchronous active-low reset clears the matrix and planes to zero; no clearing pass.
module frustum_cull_tester_core #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  fct_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output fct_pkg::out_t out_data
);

  // Command and status between sequencer and arithmetic.
  fct_pkg::cmd_t  cmd;
  fct_pkg::stat_t stat;

  // The controller takes an item only when idle with the result register empty,
  // then steps the datapath through the load/rebuild or plane-walk sequence.
  fct_ctrl #(
    .WORD_WIDTH(WORD_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_data.req_type),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cmd      (cmd),
    .stat     (stat)
  );

  // The datapath holds the matrix, the planes and all working registers.
  fct_datapath #(
    .WORD_WIDTH(WORD_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_data(in_data),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

// ----- design/fct_checker.sv -----
// Port-level checks for the frustum cull tester, bound to the top level.
// Depends on fct_pkg and frustum_cull_tester_core.
module fct_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input fct_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input fct_pkg::out_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted again right after an accept");

  // no new item while a result waits
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("ready while a result waits");

  // load acknowledgements never report visible
  a_load_vis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.resp_kind |-> !out_data.visible)
    else $error("load acknowledgement with visible set");

endmodule

bind frustum_cull_tester_core fct_checker u_fct_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
